// File: design/gcn_pkg.sv
// Shared types, constants and helper functions for the 2D gradient and cellular noise core.
// Depends on nothing; the RAM and the core refer to it by scoped names.
package gcn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int TABLE_SIZE  = 256;
	localparam int ADDR_W      = 8;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = 3;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_W       = 18;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd2;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		MODE_GRAD    = 2'd0,
		MODE_FRACTAL = 2'd1,
		MODE_CELL    = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OCTAVE,
		ST_DIV_GO,
		ST_DIVIDE,
		ST_CELL,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DONE
	} state_t;

	// Dot product of one of the eight corner gradients with the corner offset.
	function automatic logic signed [18:0] grad_val(input logic [2:0] h,
			input logic signed [17:0] gx, input logic signed [17:0] gy);
		logic signed [18:0] sx;
		logic signed [18:0] sy;
		logic signed [18:0] r;
		sx = {gx[17], gx};
		sy = {gy[17], gy};
		unique case (h)
			3'd0: r = sx + sy;
			3'd1: r = sy - sx;
			3'd2: r = sx - sy;
			3'd3: r = -sx - sy;
			3'd4: r = sx;
			3'd5: r = -sx;
			3'd6: r = sy;
			3'd7: r = -sy;
		endcase
		return r;
	endfunction

	// h * 65536 / 255 truncated equals h * 257, plus one when h is 255.
	function automatic logic [16:0] cell_off(input logic [7:0] h);
		return {1'b0, h, h} + 17'(h == 8'hFF);
	endfunction

endpackage

// File: design/gcn_perm_ram.sv
// Permutation table storage: 256 x 8 synchronous RAM, one write and one read port.
// Depends on gcn_pkg for the address width and the table size.
module gcn_perm_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [gcn_pkg::ADDR_W-1:0]  waddr,
	input  logic [7:0]                  wdata,
	input  logic [gcn_pkg::ADDR_W-1:0]  raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [gcn_pkg::TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/gcn_div.sv
// Restoring divider, one quotient bit per cycle, for the fractal normalization.
// Does not use gcn_pkg; widths are local.
module gcn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [19:0] divisor,
	output logic        done,
	output logic [17:0] quotient
);

	logic [39:0] quo_q;
	logic [19:0] dvs_q;
	logic [19:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [20:0] rem_sh;
	logic [20:0] rem_sub;

	assign rem_sh  = {rem_q, quo_q[39]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd39;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!rem_sub[20]) begin
				rem_q <= rem_sub[19:0];
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= rem_sh[19:0];
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[17:0];

endmodule

// File: design/gcn_isqrt.sv
// Digit-by-digit integer square root of a 32-bit value, one root bit per cycle.
// Used for the cellular distance; it uses no package items.
module gcn_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0] val_q;
	logic [16:0] rem_q;
	logic [15:0] root_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [18:0] rem_sh;
	logic [18:0] trial;
	logic [18:0] diff;

	assign rem_sh = {rem_q, val_q[31:30]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[29:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= diff[16:0];
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[16:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: design/gradient_and_cellular_noise_2d_core.sv
// Gradient, fractal and cellular 2D noise over a loadable permutation table.
// Load words write the table when accepted. Gradient and fractal samples run octave by
// octave (six dependent reads of the single table read port set the pace), then a
// bit-serial division. Cellular samples run table reads and squaring over the nine
// neighbor cells, then a square root unless the distance overflows. One sample at a time.
// Reset clears control state and loads the register defaults; the table is not cleared.
module gradient_and_cellular_noise_2d_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [gcn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcn_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           opcode,
	input  logic [7:0]                     entry_index,
	input  logic [7:0]                     entry_value,
	input  logic signed [31:0]             x_coord,
	input  logic signed [31:0]             y_coord,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic signed [gcn_pkg::OUT_W-1:0] noise_value
);

	// Sequencer step numbers. Within an octave, the six table reads are issued
	// back to back while the fade polynomials are worked out alongside them.
	localparam logic [3:0] OCT_LAST  = 4'd13;
	localparam logic [3:0] CELL_LAST = 4'd8;

	gcn_pkg::state_t state_q, state_d;

	// Configuration registers.
	gcn_pkg::mode_t  mode_q;
	logic [3:0]      oct_cnt_q;
	logic [16:0]     pers_q;

	// Sample context.
	logic [31:0] x_q, y_q, xs_q, ys_q;
	logic [3:0]  step_q;
	logic [gcn_pkg::OCT_W-1:0] oct_idx_q, oct_last_q;
	logic [1:0]  dxi_q, dyi_q;

	// Octave datapath.
	logic [31:0] pxx_q, pyy_q;
	logic [15:0] t3x_q, t3y_q;
	logic [19:0] qx_q, qy_q;
	logic [16:0] u_q, v_q;
	logic [7:0]  a_q, b_q;
	logic [2:0]  h00_q, h10_q, h01_q, h11_q;
	logic signed [37:0] m_q;
	logic signed [18:0] x0_q, x1_q, n_q;
	logic signed [36:0] prod_q;
	logic signed [39:0] total_q;
	logic [19:0] sum_q;
	logic [16:0] amp_q;
	logic [16:0] pers_c;

	// Cellular datapath.
	logic [7:0]  t1_q, t2_q, hx_q, hy_q;
	logic signed [18:0] ddx_q, ddy_q;
	logic [35:0] sqx_q, sqy_q, best_q;

	logic [17:0] res_q;
	logic        neg_q;
	logic        result_valid_q;
	logic [17:0] noise_q;

	// Table port and helper units.
	logic        ram_we;
	logic [7:0]  rd_addr, rdata;
	logic        div_start, div_done, sqrt_start, sqrt_done;
	logic [17:0] quo;
	logic [15:0] root;
	logic        accept, out_load;

	gcn_perm_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index),
		.wdata (entry_value),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	gcn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q[39] ? 40'(-total_q) : total_q),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (quo)
	);

	gcn_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (best_q[31:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	// Words are taken only when the sequencer is idle, so a load never overlaps
	// the reads of a sample and no forwarding around the table is needed.
	assign item_ready = (state_q == gcn_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign ram_we     = accept && (opcode == gcn_pkg::OP_LOAD);
	assign out_load   = (state_q == gcn_pkg::ST_DONE) && (!result_valid_q || result_ready);

	// Fractional parts and table cells of the current octave's coordinates.
	logic [15:0] xf, yf;
	logic [7:0]  cx, cy;
	assign xf = xs_q[15:0];
	assign yf = ys_q[15:0];
	assign cx = xs_q[23:16];
	assign cy = ys_q[23:16];

	// Fade polynomial pieces: t^3 in Q0.16 and 6t^2 - 15t + 10 in Q4.16.
	logic [31:0] t3x_p, t3y_p;
	logic [35:0] qnx, qny;
	logic [35:0] ux_p, vy_p;
	assign t3x_p = pxx_q[31:16] * xf;
	assign t3y_p = pyy_q[31:16] * yf;
	assign qnx   = ({4'b0, pxx_q} * 36'd6) + 36'd42949672960 - (({20'b0, xf} * 36'd15) << 16);
	assign qny   = ({4'b0, pyy_q} * 36'd6) + 36'd42949672960 - (({20'b0, yf} * 36'd15) << 16);
	assign ux_p  = t3x_q * qx_q;
	assign vy_p  = t3y_q * qy_q;

	// Corner gradients; the far corner offset is the fraction minus one.
	logic signed [17:0] gx0, gx1, gy0, gy1;
	logic signed [18:0] g00, g10, g01, g11;
	logic signed [19:0] dif0, dif1, dif2;
	logic signed [37:0] msh;
	assign gx0  = $signed({2'b00, xf});
	assign gx1  = $signed({2'b11, xf});
	assign gy0  = $signed({2'b00, yf});
	assign gy1  = $signed({2'b11, yf});
	assign g00  = gcn_pkg::grad_val(h00_q, gx0, gy0);
	assign g10  = gcn_pkg::grad_val(h10_q, gx1, gy0);
	assign g01  = gcn_pkg::grad_val(h01_q, gx0, gy1);
	assign g11  = gcn_pkg::grad_val(h11_q, gx1, gy1);
	assign dif0 = {g10[18], g10} - {g00[18], g00};
	assign dif1 = {g11[18], g11} - {g01[18], g01};
	assign dif2 = {x1_q[18], x1_q} - {x0_q[18], x0_q};
	assign msh  = m_q >>> 16;

	// Persistence above one acts as one.
	assign pers_c = (pers_q > 17'd65536) ? 17'd65536 : pers_q;
	logic [33:0] amp_p;
	assign amp_p = amp_q * pers_c;

	// Cellular neighbor cells; only the low eight bits of the cell index matter.
	logic [7:0] cxl, cyl;
	logic signed [18:0] dxterm, dyterm, ddx_d, ddy_d;
	logic signed [37:0] sqx_p, sqy_p;
	logic [35:0] d2;
	assign cxl    = x_q[23:16] + {6'b0, dxi_q} - 8'd1;
	assign cyl    = y_q[23:16] + {6'b0, dyi_q} - 8'd1;
	assign dxterm = (dxi_q == 2'd0) ? 19'sd65536 : ((dxi_q == 2'd1) ? 19'sd0 : -19'sd65536);
	assign dyterm = (dyi_q == 2'd0) ? 19'sd65536 : ((dyi_q == 2'd1) ? 19'sd0 : -19'sd65536);
	assign ddx_d  = $signed({3'b000, x_q[15:0]}) + dxterm
			- $signed({2'b00, gcn_pkg::cell_off(hx_q)});
	assign ddy_d  = $signed({3'b000, y_q[15:0]}) + dyterm
			- $signed({2'b00, gcn_pkg::cell_off(hy_q)});
	assign sqx_p  = ddx_q * ddx_q;
	assign sqy_p  = ddy_q * ddy_q;
	assign d2     = sqx_q + sqy_q;

	// Signed quotient with the single positive overflow case saturated.
	logic signed [18:0] qs;
	assign qs = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= gcn_pkg::MODE_GRAD;
			oct_cnt_q <= 4'd4;
			pers_q    <= 17'd32768;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				gcn_pkg::REG_NOISE_MODE:   mode_q    <= gcn_pkg::mode_t'(cfg_data[1:0]);
				gcn_pkg::REG_OCTAVE_COUNT: oct_cnt_q <= cfg_data[3:0];
				gcn_pkg::REG_PERSISTENCE:  pers_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table read address and unit starts.
	always_comb begin
		state_d    = state_q;
		rd_addr    = '0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		unique case (state_q)
			gcn_pkg::ST_IDLE: begin
				if (accept && opcode == gcn_pkg::OP_SAMPLE) begin
					unique case (mode_q)
						gcn_pkg::MODE_GRAD,
						gcn_pkg::MODE_FRACTAL: state_d = gcn_pkg::ST_OCTAVE;
						gcn_pkg::MODE_CELL:    state_d = gcn_pkg::ST_CELL;
						gcn_pkg::MODE_UNUSED:  state_d = gcn_pkg::ST_DONE;
					endcase
				end
			end
			gcn_pkg::ST_OCTAVE: begin
				unique case (step_q)
					4'd0: rd_addr = cx;
					4'd1: rd_addr = cx + 8'd1;
					4'd2: rd_addr = a_q;
					4'd3: rd_addr = b_q;
					4'd4: rd_addr = a_q + 8'd1;
					4'd5: rd_addr = b_q + 8'd1;
					default: ;
				endcase
				if (step_q == OCT_LAST && oct_idx_q == oct_last_q) begin
					state_d = gcn_pkg::ST_DIV_GO;
				end
			end
			gcn_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = gcn_pkg::ST_DIVIDE;
			end
			gcn_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = gcn_pkg::ST_DONE;
				end
			end
			gcn_pkg::ST_CELL: begin
				unique case (step_q)
					4'd0: rd_addr = cxl;
					4'd1: rd_addr = cyl + 8'd17;
					4'd2: rd_addr = t1_q;
					4'd3: rd_addr = t2_q;
					default: ;
				endcase
				if (step_q == CELL_LAST && dxi_q == 2'd2 && dyi_q == 2'd2) begin
					state_d = gcn_pkg::ST_ROOT_GO;
				end
			end
			gcn_pkg::ST_ROOT_GO: begin
				if (best_q[35:32] != 4'd0) begin
					state_d = gcn_pkg::ST_DONE;
				end else begin
					sqrt_start = 1'b1;
					state_d    = gcn_pkg::ST_ROOT;
				end
			end
			gcn_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					state_d = gcn_pkg::ST_DONE;
				end
			end
			gcn_pkg::ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					state_d = gcn_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Sequencer counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			oct_idx_q <= '0;
			dxi_q     <= '0;
			dyi_q     <= '0;
		end else if (accept) begin
			step_q    <= '0;
			oct_idx_q <= '0;
			dxi_q     <= '0;
			dyi_q     <= '0;
		end else if (state_q == gcn_pkg::ST_OCTAVE) begin
			if (step_q == OCT_LAST) begin
				step_q    <= '0;
				oct_idx_q <= oct_idx_q + 3'd1;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end else if (state_q == gcn_pkg::ST_CELL) begin
			if (step_q == CELL_LAST) begin
				step_q <= '0;
				if (dxi_q == 2'd2) begin
					dxi_q <= '0;
					dyi_q <= dyi_q + 2'd1;
				end else begin
					dxi_q <= dxi_q + 2'd1;
				end
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_coord;
			y_q     <= y_coord;
			xs_q    <= x_coord;
			ys_q    <= y_coord;
			amp_q   <= 17'd65536;
			total_q <= '0;
			sum_q   <= '0;
			best_q  <= '1;
			res_q   <= '0;
			// Gradient mode is a single octave; out-of-range counts are clamped.
			if (mode_q == gcn_pkg::MODE_GRAD || oct_cnt_q == 4'd0) begin
				oct_last_q <= '0;
			end else if (oct_cnt_q > 4'(gcn_pkg::MAX_OCTAVES)) begin
				oct_last_q <= 3'(gcn_pkg::MAX_OCTAVES - 1);
			end else begin
				oct_last_q <= 3'(oct_cnt_q - 4'd1);
			end
		end
		if (state_q == gcn_pkg::ST_OCTAVE) begin
			unique case (step_q)
				4'd0: pxx_q <= xf * xf;
				4'd1: begin
					a_q   <= rdata + cy;
					pyy_q <= yf * yf;
				end
				4'd2: begin
					b_q   <= rdata + cy;
					t3x_q <= t3x_p[31:16];
					qx_q  <= qnx[35:16];
				end
				4'd3: begin
					h00_q <= rdata[2:0];
					t3y_q <= t3y_p[31:16];
					qy_q  <= qny[35:16];
				end
				4'd4: begin
					h10_q <= rdata[2:0];
					u_q   <= ux_p[32:16];
				end
				4'd5: begin
					h01_q <= rdata[2:0];
					v_q   <= vy_p[32:16];
				end
				4'd6: h11_q <= rdata[2:0];
				4'd7: m_q <= $signed({1'b0, u_q}) * dif0;
				4'd8: begin
					x0_q <= g00 + msh[18:0];
					m_q  <= $signed({1'b0, u_q}) * dif1;
				end
				4'd9:  x1_q <= g01 + msh[18:0];
				4'd10: m_q <= $signed({1'b0, v_q}) * dif2;
				4'd11: n_q <= x0_q + msh[18:0];
				4'd12: prod_q <= n_q * $signed({1'b0, amp_q});
				4'd13: begin
					total_q <= total_q + 40'(prod_q);
					sum_q   <= sum_q + {3'b0, amp_q};
					amp_q   <= amp_p[32:16];
					xs_q    <= {xs_q[30:0], 1'b0};
					ys_q    <= {ys_q[30:0], 1'b0};
				end
				default: ;
			endcase
		end
		if (state_q == gcn_pkg::ST_DIV_GO) begin
			neg_q <= total_q[39];
		end
		if (state_q == gcn_pkg::ST_CELL) begin
			unique case (step_q)
				4'd1: t1_q <= rdata + cyl;
				4'd2: t2_q <= rdata + cxl + 8'd31;
				4'd3: hx_q <= rdata;
				4'd4: hy_q <= rdata;
				4'd5: begin
					ddx_q <= ddx_d;
					ddy_q <= ddy_d;
				end
				4'd6: sqx_q <= sqx_p[35:0];
				4'd7: sqy_q <= sqy_p[35:0];
				4'd8: begin
					if (d2 < best_q) begin
						best_q <= d2;
					end
				end
				default: ;
			endcase
		end
		if (state_q == gcn_pkg::ST_DIVIDE && div_done) begin
			res_q <= (qs == 19'sd131072) ? 18'h1FFFF : qs[17:0];
		end
		if (state_q == gcn_pkg::ST_ROOT_GO && best_q[35:32] != 4'd0) begin
			res_q <= 18'd65536;
		end
		if (state_q == gcn_pkg::ST_ROOT && sqrt_done) begin
			res_q <= {2'b00, root};
		end
	end

	// Output register: a finished word waits here while the next word may enter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			noise_q <= res_q;
		end
	end

	assign result_valid = result_valid_q;
	assign noise_value  = $signed(noise_q);

	// The helper units only report completion in the state that waits for them.
	ast_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == gcn_pkg::ST_DIVIDE)
		else $error("divider finished outside the divide state");

	ast_root_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == gcn_pkg::ST_ROOT)
		else $error("square root finished outside the root state");

	ast_octave_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcn_pkg::ST_OCTAVE |-> oct_idx_q <= oct_last_q)
		else $error("octave index ran past the configured count");

	ast_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result_valid && state_q == gcn_pkg::ST_IDLE)
		else $error("finished sample did not reach the output register");

endmodule
